@@ design/i2cm_pkg.sv @@
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command codes as they arrive on the input channel.
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_WAIT  = 3'd5
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ACK_TIMEOUT    = 2'd0,
        CFG_CONDITION_HOLD = 2'd1,
        CFG_BIT_PHASE      = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;
    localparam logic [7:0] CONDITION_HOLD_RESET = 8'd4;
    localparam logic [7:0] BIT_PHASE_RESET      = 8'd2;
    localparam logic [7:0] MSB_MASK             = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

    // What the front end decided an item is.
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_CMD  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        t_op        op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } t_queue_entry;

    typedef struct packed {
        logic       valid;
        t_cfg_idx   index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       rejected;
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl_level;
    } t_result;

    // A tick count of zero behaves as one.
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

@@ design/i2cm_front.sv @@
`timescale 1ns / 1ps

module i2cm_front
    import i2cm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [2:0]   i_command,
    input  logic [7:0]   i_tx_byte,
    input  logic         i_send_ack,
    input  logic         i_sda_level,
    output logic         o_entry_valid,
    output t_queue_entry o_entry,
    input  logic         i_pop
);

    t_queue_entry r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         push;
    t_queue_entry entry_in;

    assign o_ready       = (r_count != 2'd2);
    assign push          = i_valid && o_ready;
    assign o_entry_valid = (r_count != 2'd0);
    assign o_entry       = r_mem[r_rd_ptr];

    // Start through wait ack are commands; idle and the unused codes advance time.
    always_comb begin
        entry_in.op        = t_op'(i_command);
        entry_in.tx_byte   = i_tx_byte;
        entry_in.send_ack  = i_send_ack;
        entry_in.sda_level = i_sda_level;
        unique case (i_command) inside
            [OP_START:OP_WAIT]: entry_in.kind = KIND_CMD;
            default:            entry_in.kind = KIND_TICK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry_in;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

@@ design/i2cm_back.sv @@
`timescale 1ns / 1ps

module i2cm_back
    import i2cm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg_wr      i_cfg,
    input  logic         i_entry_valid,
    input  t_queue_entry i_entry,
    output logic         o_pop,
    output logic         o_res_valid,
    input  logic         i_res_ready,
    output t_result      o_res
);

    logic [7:0] r_ack_timeout, r_cond_hold, r_bit_phase;
    t_op        r_op,       n_op;
    logic [2:0] r_phase,    n_phase;
    logic [3:0] r_bit_idx,  n_bit_idx;
    logic [7:0] r_delay,    n_delay;
    logic [7:0] r_shift,    n_shift;
    logic [7:0] r_poll,     n_poll;
    logic       r_ack_sel,  n_ack_sel;
    logic       r_scl,      n_scl;
    logic       r_sda,      n_sda;
    logic [7:0] r_rx,       n_rx;
    logic       r_res_valid;
    t_result    r_res;
    logic       done, fail, rej;
    logic [7:0] hold_ticks, phase_ticks;

    assign o_pop       = i_entry_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign hold_ticks  = at_least_one(r_cond_hold);
    assign phase_ticks = at_least_one(r_bit_phase);

    always_comb begin
        n_op      = r_op;
        n_phase   = r_phase;
        n_bit_idx = r_bit_idx;
        n_delay   = r_delay;
        n_shift   = r_shift;
        n_poll    = r_poll;
        n_ack_sel = r_ack_sel;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_rx      = r_rx;
        done      = 1'b0;
        fail      = 1'b0;
        rej       = 1'b0;
        if (i_entry.kind == KIND_CMD) begin
            if (r_op != OP_IDLE) begin
                rej = 1'b1;
            end else begin
                n_op      = i_entry.op;
                n_bit_idx = 4'd0;
                n_poll    = 8'd0;
                n_phase   = 3'd0;
                unique case (i_entry.op)
                    OP_START: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_delay = hold_ticks;
                    end
                    OP_STOP: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_delay = hold_ticks;
                    end
                    OP_WRITE: begin
                        n_scl   = 1'b0;
                        n_sda   = |(i_entry.tx_byte & MSB_MASK);
                        n_shift = {i_entry.tx_byte[6:0], 1'b0};
                        n_delay = phase_ticks;
                    end
                    OP_READ: begin
                        n_sda     = 1'b1;
                        n_scl     = 1'b0;
                        n_shift   = 8'd0;
                        n_ack_sel = i_entry.send_ack;
                        n_delay   = phase_ticks;
                    end
                    default: begin
                        n_sda   = 1'b1;
                        n_delay = phase_ticks;
                    end
                endcase
            end
        end else if (r_op != OP_IDLE) begin
            // The ACK poll runs every tick; every other step waits out its delay.
            if (!(r_op == OP_WAIT && r_phase == 3'd2) && r_delay > 8'd1) begin
                n_delay = r_delay - 8'd1;
            end else begin
                n_delay = 8'd0;
                unique case (r_op)
                    OP_START: begin
                        if (r_phase == 3'd0) begin
                            n_sda   = 1'b0;
                            n_phase = 3'd1;
                            n_delay = hold_ticks;
                        end else begin
                            n_scl = 1'b0;
                            done  = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (r_phase == 3'd0) begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_phase = 3'd1;
                            n_delay = hold_ticks;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_WRITE: begin
                        if (r_phase == 3'd0) begin
                            n_scl   = 1'b1;
                            n_phase = 3'd1;
                            n_delay = phase_ticks;
                        end else if (r_phase == 3'd1) begin
                            n_scl   = 1'b0;
                            n_phase = 3'd2;
                            n_delay = phase_ticks;
                        end else begin
                            n_bit_idx = r_bit_idx + 4'd1;
                            if (n_bit_idx >= BITS_PER_BYTE) begin
                                done = 1'b1;
                            end else begin
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                                n_phase = 3'd0;
                                n_delay = phase_ticks;
                            end
                        end
                    end
                    OP_READ: begin
                        if (r_phase == 3'd0) begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_entry.sda_level};
                            n_phase = 3'd1;
                            n_delay = phase_ticks;
                        end else if (r_phase == 3'd1) begin
                            n_bit_idx = r_bit_idx + 4'd1;
                            n_scl     = 1'b0;
                            n_delay   = phase_ticks;
                            if (n_bit_idx >= BITS_PER_BYTE) begin
                                n_sda   = ~r_ack_sel;
                                n_phase = 3'd2;
                            end else begin
                                n_phase = 3'd0;
                            end
                        end else if (r_phase == 3'd2) begin
                            n_scl   = 1'b1;
                            n_phase = 3'd3;
                            n_delay = phase_ticks;
                        end else begin
                            n_scl = 1'b0;
                            n_rx  = r_shift;
                            done  = 1'b1;
                        end
                    end
                    default: begin
                        if (r_phase == 3'd0) begin
                            n_scl   = 1'b1;
                            n_phase = 3'd1;
                            n_delay = phase_ticks;
                        end else if (r_phase == 3'd1) begin
                            n_phase = 3'd2;
                            n_poll  = 8'd0;
                        end else if (r_phase == 3'd2) begin
                            if (!i_entry.sda_level) begin
                                n_scl = 1'b0;
                                done  = 1'b1;
                            end else if (r_poll >= r_ack_timeout) begin
                                // Timed out: drive a stop condition, then fail.
                                n_scl   = 1'b0;
                                n_sda   = 1'b0;
                                n_phase = 3'd3;
                                n_delay = hold_ticks;
                            end else begin
                                n_poll = r_poll + 8'd1;
                            end
                        end else if (r_phase == 3'd3) begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_phase = 3'd4;
                            n_delay = hold_ticks;
                        end else begin
                            done = 1'b1;
                            fail = 1'b1;
                        end
                    end
                endcase
                if (done) begin
                    n_op    = OP_IDLE;
                    n_phase = 3'd0;
                    n_delay = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RESET;
            r_cond_hold   <= CONDITION_HOLD_RESET;
            r_bit_phase   <= BIT_PHASE_RESET;
            r_op          <= OP_IDLE;
            r_phase       <= 3'd0;
            r_bit_idx     <= 4'd0;
            r_delay       <= 8'd0;
            r_shift       <= 8'd0;
            r_poll        <= 8'd0;
            r_ack_sel     <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_rx          <= 8'd0;
            r_res_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ACK_TIMEOUT:    r_ack_timeout <= i_cfg.data;
                    CFG_CONDITION_HOLD: r_cond_hold   <= i_cfg.data;
                    CFG_BIT_PHASE:      r_bit_phase   <= i_cfg.data;
                    default:            ;
                endcase
            end
            if (o_pop) begin
                r_op      <= n_op;
                r_phase   <= n_phase;
                r_bit_idx <= n_bit_idx;
                r_delay   <= n_delay;
                r_shift   <= n_shift;
                r_poll    <= n_poll;
                r_ack_sel <= n_ack_sel;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_rx      <= n_rx;
                r_res_valid <= 1'b1;
                r_res.scl_level  <= n_scl;
                r_res.sda_drive  <= n_sda;
                r_res.busy_res   <= (n_op != OP_IDLE);
                r_res.done_res   <= done;
                r_res.rx_byte    <= n_rx;
                r_res.ack_failed <= fail;
                r_res.rejected   <= rej;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    a_idle_no_delay : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == OP_IDLE) |-> (r_delay == 8'd0 && r_phase == 3'd0))
        else $error("idle sequencer holds a pending delay or phase");

    a_fail_with_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.ack_failed) |-> (r_res.done_res && !r_res.busy_res))
        else $error("ack failure reported without completion");

    a_reject_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.kind == KIND_CMD && r_op != OP_IDLE)
            |=> (r_res.rejected && r_res.busy_res && !r_res.done_res))
        else $error("busy command not rejected cleanly");

endmodule

@@ design/i2c_master_bit_engine.sv @@
`timescale 1ns / 1ps

// I2C master pin sequencer driven one item at a time.
// Input channel (i_s_*): each transfer carries a command in tuser and the
// transmit byte, the ACK choice for reads and the sampled SDA level in tdata.
// Command 0 (and the unused codes 6 and 7) is a tick that advances time by one
// delay unit; commands 1 to 5 start a start, stop, write, read or wait-for-ACK
// sequence when the sequencer is idle, and are rejected while it is busy.
// Output channel (o_m_*): exactly one result transfer per input transfer, in
// order, carrying the SCL and SDA drive levels, busy, done, the last read byte,
// the ACK-timeout flag and the rejected flag.
// Configuration channel (i_cfg_*): register 0 is the ACK timeout, 1 the start
// and stop hold time, 2 the bit phase time; writes are always accepted and
// are meant for idle periods only. Indexes beyond the list are ignored.
// Each item passes through the queue and then the result register before
// result valid rises; throughput is one item per cycle while the receiver
// does not stall, set by the sequencer step in the back end.
// A two-entry queue decouples input classification from the sequencer, and the
// result register takes the next item in the cycle its waiting result is taken.
// When the receiver stalls, the queue fills and then o_s_tready drops.
// Reset restores the default timing registers, idles the sequencer with both
// lines released, and clears the read byte to zero.

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] tx_byte, [8] send_ack, [9] sda_level, [15:10] zero
    input  logic [15:0] i_s_tdata,
    // [2:0] command
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] scl_level, [1] sda_drive, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_failed, [13] rejected, [15:14] zero
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_queue_entry entry;
    logic         entry_valid;
    logic         pop;
    t_result      res;
    t_cfg_wr      cfg;

    // Register writes always complete at once.
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = t_cfg_idx'(i_cfg_index);
    assign cfg.data    = i_cfg_data;

    i2cm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_command     (i_s_tuser),
        .i_tx_byte     (i_s_tdata[7:0]),
        .i_send_ack    (i_s_tdata[8]),
        .i_sda_level   (i_s_tdata[9]),
        .o_entry_valid (entry_valid),
        .o_entry       (entry),
        .i_pop         (pop)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_entry_valid (entry_valid),
        .i_entry       (entry),
        .o_pop         (pop),
        .o_res_valid   (o_m_tvalid),
        .i_res_ready   (i_m_tready),
        .o_res         (res)
    );

    // The result struct lists scl_level last, so it lands in bit 0.
    assign o_m_tdata = {2'b00, res};

endmodule
